>>> rtl/chc_pkg.sv
// shared constants, codes and control types of the canonical huffman code assigner
package chc_pkg;

	localparam int MAX_LENGTH  = 15;
	localparam int SYMBOLS     = 288;
	localparam int LEN_W       = 4;
	localparam int NUM_LENGTHS = 1 << LEN_W;
	localparam int CODE_W      = 16;
	localparam int SYM_W       = 9;
	localparam int CNT_W       = 9;
	localparam int TALLY_MAX   = (1 << CNT_W) - 1;
	localparam int IDX_W       = $clog2(SYMBOLS + 1);
	localparam int CMD_W       = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_COUNT  = 2'd1,
		CMD_ASSIGN = 2'd2
	} command_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FORM,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic count;
		logic form_start;
		logic form_step;
		logic emit;
		logic use_latched;
	} dp_cmd_t;

	typedef struct packed {
		logic idx_full;
		logic codes_ready;
		logic form_last;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/chc_if.sv
// valid/ready channels for input items and result items
interface chc_in_if;
	logic                        valid;
	logic                        ready;
	logic [chc_pkg::CMD_W-1:0]   command;
	logic [chc_pkg::LEN_W-1:0]   code_length;

	modport source (output valid, output command, output code_length, input ready);
	modport sink   (input valid, input command, input code_length, output ready);
endinterface

interface chc_out_if;
	logic                        valid;
	logic                        ready;
	logic [chc_pkg::SYM_W-1:0]   symbol;
	logic [chc_pkg::CODE_W-1:0]  code;
	logic [chc_pkg::LEN_W-1:0]   code_bits;

	modport source (output valid, output symbol, output code, output code_bits, input ready);
	modport sink   (input valid, input symbol, input code, input code_bits, output ready);
endinterface

>>> rtl/chc_datapath.sv
// tallies, next-code table, first-code formation and result register
module chc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  chc_pkg::dp_cmd_t              cmd,
	input  logic [chc_pkg::LEN_W-1:0]     item_len,
	output chc_pkg::dp_status_t           status,
	chc_out_if.source                     result
);

	logic [chc_pkg::CNT_W-1:0]  tally_q [chc_pkg::NUM_LENGTHS];
	logic [chc_pkg::CODE_W-1:0] next_code_q [chc_pkg::NUM_LENGTHS];
	logic [chc_pkg::IDX_W-1:0]  idx_q;
	logic [chc_pkg::CNT_W-1:0]  entries_q;
	logic                       ready_q;
	logic [chc_pkg::LEN_W-1:0]  len_q;
	logic [chc_pkg::LEN_W-1:0]  bits_q;
	logic [chc_pkg::CODE_W-1:0] acc_q;
	logic                       out_valid_q;
	logic [chc_pkg::SYM_W-1:0]  out_sym_q;
	logic [chc_pkg::CODE_W-1:0] out_code_q;
	logic [chc_pkg::LEN_W-1:0]  out_bits_q;

	logic [chc_pkg::LEN_W-1:0]  tally_addr;
	logic [chc_pkg::CNT_W-1:0]  tally_rd;
	logic                       item_len_ok;
	logic [chc_pkg::CODE_W-1:0] form_sum;
	logic [chc_pkg::CODE_W-1:0] form_code;
	logic [chc_pkg::LEN_W-1:0]  emit_len;
	logic                       emit_len_ok;
	logic [chc_pkg::CODE_W-1:0] nc_rd;
	logic                       single;
	logic                       has_res;
	logic                       bump;
	logic [chc_pkg::SYM_W-1:0]  res_sym;
	logic [chc_pkg::CODE_W-1:0] res_code;
	logic [chc_pkg::LEN_W-1:0]  res_bits;
	logic                       out_free;

	// one read port on the tally table, shared by count and formation
	assign tally_addr  = cmd.form_step ? chc_pkg::LEN_W'(bits_q - chc_pkg::LEN_W'(1)) : item_len;
	assign tally_rd    = tally_q[tally_addr];
	assign item_len_ok = (item_len != '0) &&
		(item_len <= chc_pkg::LEN_W'(chc_pkg::MAX_LENGTH));

	assign form_sum  = chc_pkg::CODE_W'(acc_q + chc_pkg::CODE_W'(tally_rd));
	assign form_code = {form_sum[chc_pkg::CODE_W-2:0], 1'b0};

	assign emit_len    = cmd.use_latched ? len_q : item_len;
	assign emit_len_ok = (emit_len != '0) &&
		(emit_len <= chc_pkg::LEN_W'(chc_pkg::MAX_LENGTH));
	assign nc_rd       = next_code_q[emit_len];

	// lone counted entry gets code 1 of length 1 at symbol zero
	assign single   = (entries_q == chc_pkg::CNT_W'(1));
	assign has_res  = single ? (idx_q == '0) : emit_len_ok;
	assign bump     = cmd.emit && !single && emit_len_ok;
	assign res_sym  = single ? '0 : chc_pkg::SYM_W'(idx_q);
	assign res_code = single ? chc_pkg::CODE_W'(1) : nc_rd;
	assign res_bits = single ? chc_pkg::LEN_W'(1) : emit_len;

	assign out_free = !out_valid_q || result.ready;

	assign status.idx_full    = (idx_q >= chc_pkg::IDX_W'(chc_pkg::SYMBOLS));
	assign status.codes_ready = ready_q;
	assign status.form_last   = (bits_q == chc_pkg::LEN_W'(chc_pkg::MAX_LENGTH));
	assign status.out_free    = out_free;

	assign result.valid     = out_valid_q;
	assign result.symbol    = out_sym_q;
	assign result.code      = out_code_q;
	assign result.code_bits = out_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < chc_pkg::NUM_LENGTHS; i++) begin
				tally_q[i] <= '0;
			end
			idx_q       <= '0;
			entries_q   <= '0;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				for (int i = 0; i < chc_pkg::NUM_LENGTHS; i++) begin
					tally_q[i] <= '0;
				end
				idx_q     <= '0;
				entries_q <= '0;
				ready_q   <= 1'b0;
			end
			if (cmd.count) begin
				if (entries_q != chc_pkg::CNT_W'(chc_pkg::TALLY_MAX)) begin
					entries_q <= chc_pkg::CNT_W'(entries_q + chc_pkg::CNT_W'(1));
				end
				if (item_len_ok && (tally_rd != chc_pkg::CNT_W'(chc_pkg::TALLY_MAX))) begin
					tally_q[item_len] <= chc_pkg::CNT_W'(tally_rd + chc_pkg::CNT_W'(1));
				end
			end
			if (cmd.form_step && status.form_last) begin
				ready_q <= 1'b1;
			end
			if (cmd.emit) begin
				idx_q <= chc_pkg::IDX_W'(idx_q + chc_pkg::IDX_W'(1));
			end
			if (cmd.emit && has_res) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.form_start) begin
			len_q  <= item_len;
			bits_q <= chc_pkg::LEN_W'(1);
			acc_q  <= '0;
		end else if (cmd.form_step) begin
			bits_q <= chc_pkg::LEN_W'(bits_q + chc_pkg::LEN_W'(1));
			acc_q  <= form_code;
		end
		if (cmd.form_step) begin
			next_code_q[bits_q] <= form_code;
		end else if (bump) begin
			next_code_q[emit_len] <= chc_pkg::CODE_W'(nc_rd + chc_pkg::CODE_W'(1));
		end
		if (cmd.emit && has_res) begin
			out_sym_q  <= res_sym;
			out_code_q <= res_code;
			out_bits_q <= res_bits;
		end
	end

endmodule

>>> rtl/chc_controller.sv
// command decode and sequencing of the first-code formation pass
module chc_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	chc_in_if.sink               item,
	input  chc_pkg::dp_status_t  status,
	output chc_pkg::dp_cmd_t     cmd
);

	chc_pkg::state_t state_q;
	chc_pkg::state_t state_nx;
	logic            take;

	assign item.ready = (state_q == chc_pkg::ST_IDLE) && status.out_free;
	assign take       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			chc_pkg::ST_IDLE: begin
				if (take && (item.command == chc_pkg::CMD_ASSIGN) &&
					!status.idx_full && !status.codes_ready) begin
					state_nx = chc_pkg::ST_FORM;
				end
			end
			chc_pkg::ST_FORM: begin
				if (status.form_last) begin
					state_nx = chc_pkg::ST_EMIT;
				end
			end
			chc_pkg::ST_EMIT: begin
				if (status.out_free) begin
					state_nx = chc_pkg::ST_IDLE;
				end
			end
			default: state_nx = chc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			chc_pkg::ST_IDLE: begin
				if (take) begin
					unique case (item.command)
						chc_pkg::CMD_CLEAR:  cmd.clear = 1'b1;
						chc_pkg::CMD_COUNT:  cmd.count = 1'b1;
						chc_pkg::CMD_ASSIGN: begin
							if (!status.idx_full) begin
								if (status.codes_ready) begin
									cmd.emit = 1'b1;
								end else begin
									cmd.form_start = 1'b1;
								end
							end
						end
						default: cmd = '0;
					endcase
				end
			end
			chc_pkg::ST_FORM: cmd.form_step = 1'b1;
			chc_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit        = 1'b1;
					cmd.use_latched = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

>>> rtl/canonical_huffman_code_assign.sv
// top level of the canonical huffman code assigner
//
//  channel  role  signals                                  transfer when
//  item     in    command[1:0] code_length[3:0]            item.valid & item.ready
//  result   out   symbol[8:0] code[15:0] code_bits[3:0]    result.valid & result.ready
//
// clear, count and assign after the codes exist are handled directly in the idle state
// the first assign after reset or a clear runs the first-code pass over all lengths,
// one length per cycle through the tally read port
// reset clears tallies, index, entry count, the codes-ready flag and the result valid at once
// a held result blocks new items only when it is not taken in that cycle
module canonical_huffman_code_assign (
	input  logic       clk,
	input  logic       arst_n,
	chc_in_if.sink     item,
	chc_out_if.source  result
);

	chc_pkg::dp_cmd_t    cmd;
	chc_pkg::dp_status_t status;

	chc_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.status (status),
		.cmd    (cmd)
	);

	chc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item_len (item.code_length),
		.status   (status),
		.result   (result)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.count, cmd.form_start, cmd.form_step, cmd.emit}))
		else $error("datapath commands overlap");

	a_no_take_in_form: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.form_step |-> !item.ready)
		else $error("item taken during first-code pass");

	a_bits_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.code_bits != '0))
		else $error("result with zero code length");

	a_emit_after_form: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.form_step && status.form_last) |=> status.codes_ready)
		else $error("codes not marked ready after pass");

endmodule
